[hdl/pcm_sample_playback_mixer_16ch_unit_defines.svh]
// Assertion macros shared by the PCM playback mixer RTL.
`ifndef PCM_SAMPLE_PLAYBACK_MIXER_16CH_UNIT_DEFINES_SVH
`define PCM_SAMPLE_PLAYBACK_MIXER_16CH_UNIT_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define PCMMIX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define PCMMIX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pcmmix_pkg.sv]
// Shared types, constants and helpers of the PCM playback mixer.
`default_nettype none

package pcmmix_pkg;

    // Parameter defaults
    localparam int SAMPLE_ADDR_BITS_DEF = 20;
    localparam int CHANNELS_DEF         = 16;
    localparam int CHANNELS_MAX         = 16;

    // Register RAM organized as 256 rows of 8 byte lanes
    localparam int REG_ADDR_W  = 11;
    localparam int ROW_BYTES   = 8;
    localparam int LANE_W      = 3;
    localparam int ROW_IDX_W   = REG_ADDR_W - LANE_W;
    localparam int REG_ROWS    = 1 << ROW_IDX_W;
    localparam int HI_ROW_BASE = 'h80 / ROW_BYTES;
    localparam logic [7:0] RAM_RESET_BYTE = 8'hFF;

    // Byte lanes in a channel's low row (offset 8*ch)
    localparam int LANE_VOL_L    = 2;
    localparam int LANE_VOL_R    = 3;
    localparam int LANE_ADDR_MID = 4;
    localparam int LANE_ADDR_HI  = 5;
    localparam int LANE_END      = 6;
    localparam int LANE_DELTA    = 7;
    // Byte lanes in a channel's high row (offset 0x80 + 8*ch)
    localparam int LANE_LOOP_LO  = 4;
    localparam int LANE_LOOP_HI  = 5;
    localparam int LANE_FLAGS    = 6;

    localparam int FLAG_BIT_STOP   = 0;
    localparam int FLAG_BIT_NOLOOP = 1;

    // Payload widths
    localparam int ROM_ADDR_W = 20;
    localparam int STEP_W     = 20;
    localparam int SHIFT_W    = 5;
    localparam int MASK_W     = 8;
    localparam int CH_ADDR_W  = 24;
    localparam int Q_FRAC     = 16;
    localparam int STEP_PROD_W = 8 + STEP_W;

    // Configuration
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_MASK   = 2'd2;
    localparam logic [STEP_W-1:0]  STEP_RST  = 20'h10000;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd16;
    localparam logic [MASK_W-1:0]  MASK_RST  = 8'd112;

    typedef enum logic [1:0] {
        OP_REG_WR   = 2'd0,
        OP_REG_RD   = 2'd1,
        OP_TICK     = 2'd2,
        OP_ROM_LOAD = 2'd3
    } op_t;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Mixing arithmetic
    localparam logic [7:0] SAMPLE_BIAS = 8'h80;
    localparam int SMP_W  = 9;
    localparam int MUL_W  = 2 * SMP_W;
    localparam int PROD_W = 17;
    localparam int SUM_W  = PROD_W + $clog2(CHANNELS_MAX) + 1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(32768);
    localparam logic signed [15:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] OUT_MIN = 16'sh8000;

    typedef logic [ROW_BYTES-1:0][7:0] row_t;

    typedef struct packed {
        logic                 en;
        logic [ROW_IDX_W-1:0] row;
    } ram_rd_t;

    typedef struct packed {
        logic                 en;
        logic [ROW_IDX_W-1:0] row;
        logic [ROW_BYTES-1:0] be;
        row_t                 data;
    } ram_wr_t;

    typedef struct packed {
        logic [STEP_W-1:0]  update_step;
        logic [SHIFT_W-1:0] bank_shift;
        logic [MASK_W-1:0]  bank_mask;
    } setup_t;

    typedef struct packed {
        logic busy;
        logic done;
    } voice_stat_t;

    // Saturate a mix sum to 16 bits
    function automatic logic signed [15:0] clamp16(input logic signed [SUM_W-1:0] v);
        logic signed [15:0] r;
        if (v > SUM_MAX) begin
            r = OUT_MAX;
        end else if (v < SUM_MIN) begin
            r = OUT_MIN;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/pcmmix_if.sv]
// Handshake interfaces for the command, result and configuration channels.
`default_nettype none

interface pcmmix_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [10:0] reg_offset;
    logic [7:0]  write_data;
    logic [19:0] rom_addr;
    logic [7:0]  rom_byte;

    modport source (output valid, op, reg_offset, write_data, rom_addr, rom_byte,
                    input ready);
    modport sink   (input valid, op, reg_offset, write_data, rom_addr, rom_byte,
                    output ready);
endinterface

interface pcmmix_rsp_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [7:0]         read_data;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;

    modport source (output valid, result_kind, read_data, left_sample, right_sample,
                    input ready);
    modport sink   (input valid, result_kind, read_data, left_sample, right_sample,
                    output ready);
endinterface

interface pcmmix_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/pcmmix_voice.sv]
// Channel pipeline of a tick: register fetch, end/loop check, sample fetch, mix.
`default_nettype none

`include "pcm_sample_playback_mixer_16ch_unit_defines.svh"

module pcmmix_voice #(
    parameter int SAMPLE_ADDR_BITS = pcmmix_pkg::SAMPLE_ADDR_BITS_DEF,
    parameter int CHANNELS         = pcmmix_pkg::CHANNELS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire pcmmix_pkg::setup_t            setup,
    input  wire pcmmix_pkg::row_t              rd_data,
    input  wire logic [7:0]                    smp_data,
    output pcmmix_pkg::ram_rd_t                rd,
    output pcmmix_pkg::ram_wr_t                wr,
    output logic                               smp_rd_en,
    output logic [SAMPLE_ADDR_BITS-1:0]        smp_idx,
    output pcmmix_pkg::voice_stat_t            stat,
    output logic signed [15:0]                 left,
    output logic signed [15:0]                 right
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RW   = pcmmix_pkg::ROW_IDX_W;
    localparam int AW   = pcmmix_pkg::CH_ADDR_W;

    // Issue sequencer: high row then low row per channel
    logic            busy_reg;
    logic            issue_on_reg;
    logic            issue_ph_reg;
    logic [CH_W-1:0] issue_ch_reg;

    // Stage valids and channel tags
    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [CH_W-1:0] s1_ch_reg, s2_ch_reg, s3_ch_reg;

    // Per-stage payload
    pcmmix_pkg::row_t hi_row_reg;
    logic [AW-1:0]    addr_sel_reg;
    logic [7:0]       vol_l_reg, vol_r_reg;
    logic [pcmmix_pkg::STEP_PROD_W-1:0] step_prod_reg;
    logic             proc_reg, act_reg;
    logic signed [pcmmix_pkg::PROD_W-1:0] prod_l_reg, prod_r_reg;
    logic signed [pcmmix_pkg::SUM_W-1:0]  sum_l_reg, sum_r_reg;

    // Hidden address low byte per channel
    logic [7:0] addr_lo_reg [CHANNELS];

    // Stage C signals
    logic [7:0]                  c_flags, c_end_next, c_flags_new, c_bank;
    logic                        c_proc, c_hit, c_stop, c_reload;
    logic [AW-1:0]               c_addr, c_addr_sel;
    logic [SAMPLE_ADDR_BITS-1:0] c_base;

    // Stage D signals
    logic [AW-1:0]                  d_addr_new;
    logic signed [pcmmix_pkg::SMP_W-1:0] d_smp;
    logic signed [pcmmix_pkg::MUL_W-1:0] d_mul_l, d_mul_r;

    // Register RAM read requests
    always_comb
    begin
        rd.en  = issue_on_reg;
        rd.row = issue_ph_reg ? RW'(issue_ch_reg)
                              : RW'(pcmmix_pkg::HI_ROW_BASE) + RW'(issue_ch_reg);
    end

    // Stage C: end check, loop reload, banked sample index
    always_comb
    begin
        c_flags     = hi_row_reg[pcmmix_pkg::LANE_FLAGS];
        c_proc      = !c_flags[pcmmix_pkg::FLAG_BIT_STOP];
        c_addr      = {rd_data[pcmmix_pkg::LANE_ADDR_HI], rd_data[pcmmix_pkg::LANE_ADDR_MID],
                       addr_lo_reg[s2_ch_reg]};
        c_end_next  = rd_data[pcmmix_pkg::LANE_END] + 8'd1;
        c_hit       = (c_addr[AW-1:16] == c_end_next);
        c_reload    = c_hit && !c_flags[pcmmix_pkg::FLAG_BIT_NOLOOP];
        c_stop      = c_hit && c_flags[pcmmix_pkg::FLAG_BIT_NOLOOP];
        c_addr_sel  = c_reload ? {hi_row_reg[pcmmix_pkg::LANE_LOOP_HI],
                                  hi_row_reg[pcmmix_pkg::LANE_LOOP_LO], 8'h00}
                               : c_addr;
        c_flags_new = c_flags;
        c_flags_new[pcmmix_pkg::FLAG_BIT_STOP] = c_flags[pcmmix_pkg::FLAG_BIT_STOP] | c_stop;
        c_bank      = c_flags & setup.bank_mask;
        c_base      = SAMPLE_ADDR_BITS'(c_bank) << setup.bank_shift;
        smp_idx     = c_base + SAMPLE_ADDR_BITS'(c_addr_sel[AW-1:8]);
        smp_rd_en   = s2_valid_reg && c_proc && !c_stop;
    end

    // Stage D: advance address, scale sample by volumes
    always_comb
    begin
        d_addr_new = act_reg
                   ? addr_sel_reg + AW'(step_prod_reg[pcmmix_pkg::STEP_PROD_W-1:pcmmix_pkg::Q_FRAC])
                   : addr_sel_reg;
        d_smp   = $signed({1'b0, smp_data}) - $signed({1'b0, pcmmix_pkg::SAMPLE_BIAS});
        d_mul_l = d_smp * $signed({1'b0, vol_l_reg});
        d_mul_r = d_smp * $signed({1'b0, vol_r_reg});
    end

    // Write-back: flags from stage C, address bytes from stage D (never together)
    always_comb
    begin
        wr = '0;
        if (s2_valid_reg && c_proc && c_stop) begin
            wr.en   = 1'b1;
            wr.row  = RW'(pcmmix_pkg::HI_ROW_BASE) + RW'(s2_ch_reg);
            wr.be[pcmmix_pkg::LANE_FLAGS]   = 1'b1;
            wr.data[pcmmix_pkg::LANE_FLAGS] = c_flags_new;
        end else if (s3_valid_reg && proc_reg) begin
            wr.en   = 1'b1;
            wr.row  = RW'(s3_ch_reg);
            wr.be[pcmmix_pkg::LANE_ADDR_MID]   = 1'b1;
            wr.be[pcmmix_pkg::LANE_ADDR_HI]    = 1'b1;
            wr.data[pcmmix_pkg::LANE_ADDR_MID] = d_addr_new[15:8];
            wr.data[pcmmix_pkg::LANE_ADDR_HI]  = d_addr_new[AW-1:16];
        end
    end

    // Status and mixed output
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && !issue_on_reg && !s1_valid_reg && !s2_valid_reg
                       && !s3_valid_reg && !s4_valid_reg;
    assign left  = pcmmix_pkg::clamp16(sum_l_reg);
    assign right = pcmmix_pkg::clamp16(sum_r_reg);

    // Sequencer, pipeline stages and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            issue_on_reg  <= 1'b0;
            issue_ph_reg  <= 1'b0;
            issue_ch_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s1_ch_reg     <= '0;
            s2_ch_reg     <= '0;
            s3_ch_reg     <= '0;
            hi_row_reg    <= '0;
            addr_sel_reg  <= '0;
            vol_l_reg     <= '0;
            vol_r_reg     <= '0;
            step_prod_reg <= '0;
            proc_reg      <= 1'b0;
            act_reg       <= 1'b0;
            prod_l_reg    <= '0;
            prod_r_reg    <= '0;
            sum_l_reg     <= '0;
            sum_r_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                addr_lo_reg[i] <= 8'h00;
            end
        end else begin
            // issue
            if (start) begin
                busy_reg     <= 1'b1;
                issue_on_reg <= 1'b1;
                issue_ph_reg <= 1'b0;
                issue_ch_reg <= '0;
                sum_l_reg    <= '0;
                sum_r_reg    <= '0;
            end else if (issue_on_reg) begin
                issue_ph_reg <= !issue_ph_reg;
                if (issue_ph_reg) begin
                    if (issue_ch_reg == CH_W'(CHANNELS - 1)) begin
                        issue_on_reg <= 1'b0;
                    end else begin
                        issue_ch_reg <= issue_ch_reg + 1'b1;
                    end
                end
            end else if (stat.done) begin
                busy_reg <= 1'b0;
            end

            // stage B: high row arrives
            s1_valid_reg <= issue_on_reg && !issue_ph_reg;
            s1_ch_reg    <= issue_ch_reg;
            if (s1_valid_reg) begin
                hi_row_reg <= rd_data;
            end
            s2_valid_reg <= s1_valid_reg;
            s2_ch_reg    <= s1_ch_reg;

            // stage C registers
            s3_valid_reg <= s2_valid_reg;
            s3_ch_reg    <= s2_ch_reg;
            if (s2_valid_reg) begin
                addr_sel_reg  <= c_addr_sel;
                vol_l_reg     <= rd_data[pcmmix_pkg::LANE_VOL_L];
                vol_r_reg     <= rd_data[pcmmix_pkg::LANE_VOL_R];
                step_prod_reg <= pcmmix_pkg::STEP_PROD_W'(rd_data[pcmmix_pkg::LANE_DELTA])
                               * pcmmix_pkg::STEP_PROD_W'(setup.update_step);
                proc_reg      <= c_proc;
                act_reg       <= c_proc && !c_stop;
            end

            // stage D: low byte update and products
            if (s3_valid_reg && proc_reg) begin
                addr_lo_reg[s3_ch_reg] <= act_reg ? d_addr_new[7:0] : 8'h00;
            end
            s4_valid_reg <= s3_valid_reg && act_reg;
            prod_l_reg   <= d_mul_l[pcmmix_pkg::PROD_W-1:0];
            prod_r_reg   <= d_mul_r[pcmmix_pkg::PROD_W-1:0];

            // stage E: accumulate
            if (s4_valid_reg) begin
                sum_l_reg <= sum_l_reg + pcmmix_pkg::SUM_W'(prod_l_reg);
                sum_r_reg <= sum_r_reg + pcmmix_pkg::SUM_W'(prod_r_reg);
            end
        end
    end

    // Checks
    `PCMMIX_ASSERT_NOW(a_wr_port_free, clk, rst_n, s2_valid_reg, !s3_valid_reg, "flag and address write-back overlap")
    `PCMMIX_ASSERT_NOW(a_low_row_follows, clk, rst_n, s1_valid_reg, rd.en && rd.row == RW'(s1_ch_reg), "low row read does not follow high row")
    `PCMMIX_ASSERT_NOW(a_mix_in_tick, clk, rst_n, s4_valid_reg, busy_reg, "mix stage active outside a tick")
    `PCMMIX_ASSERT_NEXT(a_done_ends, clk, rst_n, stat.done && !start, !busy_reg, "tick did not end after done")

endmodule

`default_nettype wire

[hdl/pcm_sample_playback_mixer_16ch_unit.sv]
// Sixteen-channel PCM sample playback mixer: top level with register and sample memories.
//
// Commands arrive on cmd, results leave on rsp, and update_step, bank_shift and bank_mask
// are written on cfg (index 0, 1, 2). The user must write them only while the block is
// idle; the block itself does not enforce this. After reset the block sweeps the 2 KiB
// register RAM to 0xFF, one 8-byte row a cycle, and takes no command until that sweep
// ends. A register write or a sample memory load is done on acceptance. A register read
// returns its byte on rsp after passing through ST_READ and ST_EMIT. In a tick each
// channel needs two fetches (its settings row and its loop/flag row) through the single
// read port of the register RAM, and the channel pipeline must then drain. One command is
// worked on at a time; a new one is accepted while a finished result waits on rsp.
`default_nettype none

`include "pcm_sample_playback_mixer_16ch_unit_defines.svh"

module pcm_sample_playback_mixer_16ch_unit #(
    parameter int SAMPLE_ADDR_BITS = pcmmix_pkg::SAMPLE_ADDR_BITS_DEF,
    parameter int CHANNELS         = pcmmix_pkg::CHANNELS_DEF
) (
    input wire logic      clk,
    input wire logic      rst_n,
    pcmmix_cmd_if.sink    cmd,
    pcmmix_rsp_if.source  rsp,
    pcmmix_cfg_if.sink    cfg
);

    localparam int RW = pcmmix_pkg::ROW_IDX_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_TICK,
        ST_EMIT
    } state_t;

    state_t                     state_reg;
    logic [RW-1:0]              clr_row_reg;
    logic [pcmmix_pkg::LANE_W-1:0] lane_reg;
    logic                       res_kind_reg;
    logic [7:0]                 res_data_reg;
    logic signed [15:0]         res_left_reg, res_right_reg;
    logic                       rsp_valid_reg;
    logic                       rsp_kind_reg;
    logic [7:0]                 rsp_data_reg;
    logic signed [15:0]         rsp_left_reg, rsp_right_reg;

    pcmmix_pkg::setup_t setup_reg;

    // Memories
    pcmmix_pkg::row_t reg_mem [pcmmix_pkg::REG_ROWS];
    pcmmix_pkg::row_t ram_q_reg;
    logic [7:0]       smp_mem [2**SAMPLE_ADDR_BITS];
    logic [7:0]       smp_q_reg;

    pcmmix_pkg::ram_rd_t ram_rd, v_rd;
    pcmmix_pkg::ram_wr_t ram_wr, v_wr;
    logic                        v_smp_rd_en;
    logic [SAMPLE_ADDR_BITS-1:0] v_smp_idx;
    pcmmix_pkg::voice_stat_t     v_stat;
    logic signed [15:0]          v_left, v_right;

    pcmmix_pkg::op_t cmd_op;
    logic            cmd_fire;
    logic            tick_start;

    assign cmd_op     = pcmmix_pkg::op_t'(cmd.op);
    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign tick_start = cmd_fire && (cmd_op == pcmmix_pkg::OP_TICK);

    assign cfg.ready  = 1'b1;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_kind  = rsp_kind_reg;
    assign rsp.read_data    = rsp_data_reg;
    assign rsp.left_sample  = rsp_left_reg;
    assign rsp.right_sample = rsp_right_reg;

    // Channel pipeline
    pcmmix_voice #(
        .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS),
        .CHANNELS         (CHANNELS)
    ) u_voice (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (tick_start),
        .setup     (setup_reg),
        .rd_data   (ram_q_reg),
        .smp_data  (smp_q_reg),
        .rd        (v_rd),
        .wr        (v_wr),
        .smp_rd_en (v_smp_rd_en),
        .smp_idx   (v_smp_idx),
        .stat      (v_stat),
        .left      (v_left),
        .right     (v_right)
    );

    // Register RAM port selection
    always_comb
    begin
        ram_rd = '0;
        ram_wr = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_wr.en   = 1'b1;
                ram_wr.row  = clr_row_reg;
                ram_wr.be   = '1;
                ram_wr.data = {pcmmix_pkg::ROW_BYTES{pcmmix_pkg::RAM_RESET_BYTE}};
            end
            ST_IDLE: begin
                if (cmd_fire && cmd_op == pcmmix_pkg::OP_REG_WR) begin
                    ram_wr.en   = 1'b1;
                    ram_wr.row  = cmd.reg_offset[pcmmix_pkg::REG_ADDR_W-1:pcmmix_pkg::LANE_W];
                    ram_wr.be   = pcmmix_pkg::ROW_BYTES'(1)
                                  << cmd.reg_offset[pcmmix_pkg::LANE_W-1:0];
                    ram_wr.data = {pcmmix_pkg::ROW_BYTES{cmd.write_data}};
                end
                if (cmd_fire && cmd_op == pcmmix_pkg::OP_REG_RD) begin
                    ram_rd.en  = 1'b1;
                    ram_rd.row = cmd.reg_offset[pcmmix_pkg::REG_ADDR_W-1:pcmmix_pkg::LANE_W];
                end
            end
            ST_TICK: begin
                ram_rd = v_rd;
                ram_wr = v_wr;
            end
            default: begin
            end
        endcase
    end

    // Register RAM: byte-lane write, registered read
    always_ff @(posedge clk)
    begin
        if (ram_wr.en) begin
            for (int b = 0; b < pcmmix_pkg::ROW_BYTES; b++) begin
                if (ram_wr.be[b]) begin
                    reg_mem[ram_wr.row][b] <= ram_wr.data[b];
                end
            end
        end
        if (ram_rd.en) begin
            ram_q_reg <= reg_mem[ram_rd.row];
        end
    end

    // Sample memory: load port and registered read for the pipeline
    always_ff @(posedge clk)
    begin
        if (cmd_fire && cmd_op == pcmmix_pkg::OP_ROM_LOAD) begin
            smp_mem[SAMPLE_ADDR_BITS'(cmd.rom_addr)] <= cmd.rom_byte;
        end
        if (v_smp_rd_en) begin
            smp_q_reg <= smp_mem[v_smp_idx];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            setup_reg.update_step <= pcmmix_pkg::STEP_RST;
            setup_reg.bank_shift  <= pcmmix_pkg::SHIFT_RST;
            setup_reg.bank_mask   <= pcmmix_pkg::MASK_RST;
        end else if (cfg.valid && cfg.ready) begin
            case (cfg.index)
                pcmmix_pkg::CFG_UPDATE_STEP:
                    setup_reg.update_step <= cfg.data[pcmmix_pkg::STEP_W-1:0];
                pcmmix_pkg::CFG_BANK_SHIFT:
                    setup_reg.bank_shift  <= cfg.data[pcmmix_pkg::SHIFT_W-1:0];
                pcmmix_pkg::CFG_BANK_MASK:
                    setup_reg.bank_mask   <= cfg.data[pcmmix_pkg::MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control FSM and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            lane_reg      <= '0;
            res_kind_reg  <= pcmmix_pkg::KIND_READ;
            res_data_reg  <= '0;
            res_left_reg  <= '0;
            res_right_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_kind_reg  <= pcmmix_pkg::KIND_READ;
            rsp_data_reg  <= '0;
            rsp_left_reg  <= '0;
            rsp_right_reg <= '0;
        end else begin
            // emit reloads the output register itself
            if (rsp_valid_reg && rsp.ready && state_reg != ST_EMIT) begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_row_reg <= clr_row_reg + 1'b1;
                    if (clr_row_reg == RW'(pcmmix_pkg::REG_ROWS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd_fire) begin
                        case (cmd_op)
                            pcmmix_pkg::OP_REG_RD: begin
                                lane_reg  <= cmd.reg_offset[pcmmix_pkg::LANE_W-1:0];
                                state_reg <= ST_READ;
                            end
                            pcmmix_pkg::OP_TICK: begin
                                state_reg <= ST_TICK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    res_kind_reg  <= pcmmix_pkg::KIND_READ;
                    res_data_reg  <= ram_q_reg[lane_reg];
                    res_left_reg  <= '0;
                    res_right_reg <= '0;
                    state_reg     <= ST_EMIT;
                end
                ST_TICK: begin
                    if (v_stat.done) begin
                        res_kind_reg  <= pcmmix_pkg::KIND_SAMPLE;
                        res_data_reg  <= '0;
                        res_left_reg  <= v_left;
                        res_right_reg <= v_right;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!rsp_valid_reg || rsp.ready) begin
                        rsp_valid_reg <= 1'b1;
                        rsp_kind_reg  <= res_kind_reg;
                        rsp_data_reg  <= res_data_reg;
                        rsp_left_reg  <= res_left_reg;
                        rsp_right_reg <= res_right_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    `PCMMIX_ASSERT_NOW(a_rsp_from_emit, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg == ST_EMIT), "result raised outside emit")
    `PCMMIX_ASSERT_NOW(a_read_no_audio, clk, rst_n, rsp_valid_reg && rsp_kind_reg == pcmmix_pkg::KIND_READ, rsp_left_reg == 16'sd0 && rsp_right_reg == 16'sd0, "read result carries audio")
    `PCMMIX_ASSERT_NOW(a_voice_in_tick, clk, rst_n, v_stat.busy, state_reg == ST_TICK, "channel pipeline busy outside a tick")
    `PCMMIX_ASSERT_NEXT(a_read_seq, clk, rst_n, cmd_fire && cmd_op == pcmmix_pkg::OP_REG_RD, state_reg == ST_READ, "register read did not start")

endmodule

`default_nettype wire
